// ===== rtl/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the PPU scroll address unit.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned AddrW  = 15;
  localparam int unsigned FineW  = 3;
  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // address field masks
  localparam logic [AddrW-1:0] VertScrollBits = 15'h73e0;
  localparam logic [AddrW-1:0] DataWrapMask   = 15'h3fff;
  localparam logic [AddrW-1:0] HorizBits      = 15'h041f;
  localparam logic [AddrW-1:0] NtHBit         = 15'h0400;
  localparam logic [AddrW-1:0] NtVBit         = 15'h0800;

  typedef enum logic [OpW-1:0] {
    OP_CTRL   = 3'd0,
    OP_MASK   = 3'd1,
    OP_SCROLL = 3'd2,
    OP_ADDR   = 3'd3,
    OP_DATA   = 3'd4,
    OP_STATUS = 3'd5,
    OP_TICK   = 3'd6,
    OP_LINE   = 3'd7
  } psa_op_e;

  typedef struct packed {
    logic [AddrW-1:0] cur;
    logic [AddrW-1:0] tmp;
    logic [FineW-1:0] fine_x;
    logic [FineW-1:0] fine_x_rl;
    logic             toggle;
    logic             step_row;
    logic             render;
  } psa_state_t;

endpackage

// ===== rtl/psa_update.sv =====
// ----------------------------------------------------------------------------
// psa_update
// Next-state logic of the scroll registers for one event.
// ----------------------------------------------------------------------------
module psa_update import psa_pkg::*; (
  input  psa_state_t       state_i,
  input  psa_op_e          op_i,
  input  logic             frame_copy_i,
  input  logic [ByteW-1:0] data_i,
  output psa_state_t       state_o
);

  logic [AddrW-1:0] vert_addr;
  logic [2:0]       fy;
  logic [4:0]       cy;
  logic             flip_v;
  logic [AddrW-1:0] inc;
  logic [AddrW-1:0] data_sum;
  logic [FineW-1:0] fx_next;
  logic [AddrW-1:0] tmp_lo;

  // vertical increment of the current address
  always_comb begin
    fy     = state_i.cur[14:12];
    cy     = state_i.cur[9:5];
    flip_v = 1'b0;
    if (fy != 3'd7) begin
      fy = fy + 3'd1;
    end else begin
      fy = 3'd0;
      if (cy == 5'd29) begin
        cy     = 5'd0;
        flip_v = 1'b1;
      end else if (cy == 5'd31) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
    end
    vert_addr = (state_i.cur & ~VertScrollBits) ^ (flip_v ? NtVBit : '0);
    vert_addr[14:12] = fy;
    vert_addr[9:5]   = cy;
  end

  assign inc      = state_i.step_row ? 15'd32 : 15'd1;
  assign data_sum = (state_i.cur + inc) & DataWrapMask;
  assign fx_next  = state_i.fine_x + 3'd1;
  assign tmp_lo   = {state_i.tmp[14:8], data_i};

  always_comb begin
    state_o = state_i;
    case (op_i)
      OP_CTRL: begin
        state_o.step_row  = data_i[2];
        state_o.tmp[11:10] = data_i[1:0];
      end
      OP_MASK: begin
        state_o.render = data_i[3] | data_i[4];
      end
      OP_SCROLL: begin
        if (state_i.toggle) begin
          state_o.tmp[9:5]   = data_i[7:3];
          state_o.tmp[14:12] = data_i[2:0];
        end else begin
          state_o.tmp[4:0]   = data_i[7:3];
          state_o.fine_x_rl  = data_i[2:0];
          state_o.fine_x     = data_i[2:0];
        end
        state_o.toggle = ~state_i.toggle;
      end
      OP_ADDR: begin
        if (state_i.toggle) begin
          state_o.tmp = tmp_lo;
          state_o.cur = tmp_lo;
        end else begin
          state_o.tmp = {1'b0, data_i[5:0], state_i.tmp[7:0]};
        end
        state_o.toggle = ~state_i.toggle;
      end
      OP_DATA: begin
        state_o.cur = data_sum;
      end
      OP_STATUS: begin
        state_o.toggle = 1'b0;
      end
      OP_TICK: begin
        if (state_i.render) begin
          state_o.fine_x = fx_next;
          if (fx_next == '0) begin
            if (state_i.cur[4:0] == 5'h1f) begin
              state_o.cur      = state_i.cur ^ NtHBit;
              state_o.cur[4:0] = 5'd0;
            end else begin
              state_o.cur = state_i.cur + 15'd1;
            end
          end
        end
      end
      OP_LINE: begin
        if (state_i.render) begin
          if (frame_copy_i) begin
            state_o.cur = state_i.tmp;
          end else begin
            state_o.cur = (vert_addr & ~HorizBits) | (state_i.tmp & HorizBits);
          end
          state_o.fine_x = state_i.fine_x_rl;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== rtl/ppu_scroll_address_unit.sv =====
// ----------------------------------------------------------------------------
// ppu_scroll_address_unit
// Current/temporary VRAM address, fine X scroll and write toggle of a PPU.
// ----------------------------------------------------------------------------
// Each input transfer is one event (register write, data-port access, status
// read, pixel tick, scanline end or frame copy) and produces exactly one
// output transfer carrying the current address, fine X, the write toggle and
// the render-enable flag as they stand after the event. The scroll state
// registers update at the input transfer and double as the output register,
// so a new event is taken every cycle while the output side keeps up. The
// input is stalled only while a result waits and the sink does not take it;
// input ready follows output ready in that case.
// ----------------------------------------------------------------------------
module ppu_scroll_address_unit import psa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // opcode[2:0], data_byte[10:3], zero
  input  logic                s_axis_tuser,   // frame_copy
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // vram_address[14:0], fine_x_now[17:15],
                                              // toggle_now[18], rendering_now[19], zero
);

  psa_state_t state_q, state_d;
  logic       out_valid_q;
  logic       s_fire;
  psa_op_e    op;

  // a new event may enter whenever the pending result is gone or leaving
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign op            = psa_op_e'(s_axis_tdata[OpW-1:0]);

  psa_update u_update (
    .state_i      (state_q),
    .op_i         (op),
    .frame_copy_i (s_axis_tuser),
    .data_i       (s_axis_tdata[OpW+ByteW-1:OpW]),
    .state_o      (state_d)
  );

  // scroll state, also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, state_q.render, state_q.toggle, state_q.fine_x, state_q.cur};

  // data-port access wraps into the 14-bit space
  a_data_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && op == OP_DATA |=> !state_q.cur[14])
    else $error("data access left address bit 14 set");

  // status read clears the toggle
  a_status_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && op == OP_STATUS |=> !state_q.toggle)
    else $error("status read did not clear toggle");

  // scroll and address writes flip the toggle
  a_toggle_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (op == OP_SCROLL || op == OP_ADDR) |=> state_q.toggle != $past(state_q.toggle))
    else $error("register write did not flip toggle");

  // render events do nothing while rendering is off
  a_idle_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (op == OP_TICK || op == OP_LINE) && !state_q.render
    |=> $stable(state_q.cur) && $stable(state_q.fine_x))
    else $error("render event moved address with rendering off");

  // every accepted event leaves a result pending
  a_result_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid)
    else $error("accepted event produced no result");

endmodule
